@@ src/rfo_pkg.sv @@
// shared types, codes and reset constants of the reflow oven profile controller
`default_nettype none

package rfo_pkg;

    // phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PREHEAT = 2'd1;
    localparam logic [1:0] PH_REFLOW  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PREHEAT_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_REFLOW_THRESHOLD    = 2'd1;
    localparam logic [1:0] REG_PREHEAT_HALF_CYCLES = 2'd2;
    localparam logic [1:0] REG_REFLOW_HALF_CYCLES  = 2'd3;

    // register reset values
    localparam logic [15:0] RST_PREHEAT_THRESHOLD   = 16'd41200;
    localparam logic [15:0] RST_REFLOW_THRESHOLD    = 16'd36000;
    localparam logic [15:0] RST_PREHEAT_HALF_CYCLES = 16'd3500;
    localparam logic [15:0] RST_REFLOW_HALF_CYCLES  = 16'd4500;

    // idle blink comes from this counter bit
    localparam int BLINK_BIT = 4;

    typedef struct packed {
        logic [15:0] preheat_threshold;
        logic [15:0] reflow_threshold;
        logic [15:0] preheat_half_cycles;
        logic [15:0] reflow_half_cycles;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] tick_count;
        logic        prev_sense;
        logic [15:0] filter_value;
        logic        heat_call;
        logic        led_level;
    } t_state;

    typedef struct packed {
        logic        button_pressed;
        logic        sense_level;
        logic [15:0] adc_sample;
    } t_poll;

    typedef struct packed {
        logic        fire_triac;
        logic        led_on;
        logic [1:0]  phase;
        logic        heater_on;
        logic [15:0] filtered_level;
    } t_result;

endpackage

`default_nettype wire

@@ src/rfo_step.sv @@
// next-state and result logic for one poll
`default_nettype none

module rfo_step
    import rfo_pkg::*;
(
    input  var t_cfg    i_cfg,
    input  var t_state  i_state,
    input  var t_poll   i_poll,
    output t_state      o_state,
    output t_result     o_result
);

    logic        fire;
    logic [15:0] tick_inc;
    logic [15:0] filt_keep;
    logic [15:0] filt_new;
    t_state      nx;

    assign tick_inc  = i_state.tick_count + 16'd1;
    assign filt_keep = i_state.filter_value - {2'b00, i_state.filter_value[15:2]};
    assign filt_new  = {2'b00, i_poll.adc_sample[15:2]} + filt_keep;

    always_comb begin
        nx   = i_state;
        fire = 1'b0;
        if (i_state.phase != PH_PREHEAT && i_state.phase != PH_REFLOW) begin
            // idle, unused code too
            nx.phase = PH_IDLE;
            if (i_poll.button_pressed) begin
                nx.phase      = PH_PREHEAT;
                nx.led_level  = 1'b1;
                nx.tick_count = 16'd0;
            end else begin
                nx.tick_count = tick_inc;
                nx.led_level  = tick_inc[BLINK_BIT];
            end
        end else begin
            if (i_poll.sense_level) begin
                nx.prev_sense = 1'b1;
            end else begin
                if (i_state.prev_sense) begin
                    // falling edge: one half-cycle
                    fire          = i_state.heat_call;
                    nx.tick_count = tick_inc;
                    if (i_state.phase == PH_PREHEAT) begin
                        nx.led_level = ~i_state.led_level;
                    end
                end
                nx.prev_sense = 1'b0;
            end

            nx.filter_value = filt_new;

            if (i_state.phase == PH_PREHEAT) begin
                nx.heat_call = (filt_new >= i_cfg.preheat_threshold);
                if (nx.tick_count > i_cfg.preheat_half_cycles) begin
                    nx.phase      = PH_REFLOW;
                    nx.led_level  = 1'b1;
                    nx.tick_count = 16'd0;
                end
            end else begin
                nx.heat_call = (filt_new >= i_cfg.reflow_threshold);
                if (nx.tick_count > i_cfg.reflow_half_cycles) begin
                    nx.phase      = PH_IDLE;
                    nx.tick_count = 16'd0;
                end
            end
        end
    end

    assign o_state                 = nx;
    assign o_result.fire_triac     = fire;
    assign o_result.led_on         = nx.led_level;
    assign o_result.phase          = nx.phase;
    assign o_result.heater_on      = nx.heat_call;
    assign o_result.filtered_level = nx.filter_value;

endmodule

`default_nettype wire

@@ src/reflow_oven_profile_controller_top.sv @@
// top level of the reflow oven profile controller: poll register, step logic, result register
`default_nettype none

// Each input beat is one poll (start button, mains sense level, left-adjusted
// thermistor sample) and yields exactly one result beat. A poll is captured in
// an input register and, once the result register is free, the step logic
// updates the controller state and loads the result register, which holds the
// result beat. The block takes one poll every cycle while the result side does
// not stall; the single state update path sets that rate. The input register
// can take a poll while a result waits to be taken. In idle the LED blinks
// from bit 4 of a poll counter and a press starts preheat; while running each
// falling sense edge counts one mains half-cycle, fires the triac when the
// heater is requested and toggles the LED in preheat. The sample is averaged
// as new = old - old/4 + sample/4 and compared with the phase threshold. When
// the half-cycle count exceeds the phase duration, preheat moves to reflow and
// reflow returns to idle. Registers: 0 preheat threshold, 1 reflow threshold,
// 2 preheat half-cycles, 3 reflow half-cycles; write them only while no poll
// is in flight.
module reflow_oven_profile_controller_top
    import rfo_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,

    // configuration write port
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,

    // poll channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_button_pressed,
    input  wire         i_sense_level,
    input  wire  [15:0] i_adc_sample,

    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_fire_triac,
    output logic        o_led_on,
    output logic [1:0]  o_phase,
    output logic        o_heater_on,
    output logic [15:0] o_filtered_level
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_poll   r_in;
    logic    r_in_valid;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;

    logic    out_free;     // result register can take a new beat
    logic    step_go;      // poll in the input register is processed now
    logic    in_take;      // poll beat accepted

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign step_go  = r_in_valid & out_free;
    assign in_take  = i_in_valid & ~o_in_stall;

    // input register is busy only while its poll cannot move on
    assign o_in_stall = r_in_valid & ~out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preheat_threshold   <= RST_PREHEAT_THRESHOLD;
            r_cfg.reflow_threshold    <= RST_REFLOW_THRESHOLD;
            r_cfg.preheat_half_cycles <= RST_PREHEAT_HALF_CYCLES;
            r_cfg.reflow_half_cycles  <= RST_REFLOW_HALF_CYCLES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PREHEAT_THRESHOLD:   r_cfg.preheat_threshold   <= i_cfg_data;
                REG_REFLOW_THRESHOLD:    r_cfg.reflow_threshold    <= i_cfg_data;
                REG_PREHEAT_HALF_CYCLES: r_cfg.preheat_half_cycles <= i_cfg_data;
                REG_REFLOW_HALF_CYCLES:  r_cfg.reflow_half_cycles  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // poll register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.button_pressed <= i_button_pressed;
            r_in.sense_level    <= i_sense_level;
            r_in.adc_sample     <= i_adc_sample;
        end
    end

    rfo_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_poll   (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // controller state, advances once per processed poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.tick_count   <= 16'd0;
            r_state.prev_sense   <= 1'b0;
            r_state.filter_value <= 16'd0;
            r_state.heat_call    <= 1'b0;
            r_state.led_level    <= 1'b0;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_fire_triac     = r_out.fire_triac;
    assign o_led_on         = r_out.led_on;
    assign o_phase          = r_out.phase;
    assign o_heater_on      = r_out.heater_on;
    assign o_filtered_level = r_out.filtered_level;

    // the input side only holds off while a poll is parked
    a_stall_needs_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty poll register");

    // state moves only when a poll is processed
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step_go |=> $stable(r_state))
        else $error("controller state changed without a poll");

    // a press in idle lands in preheat with a cleared counter and the led lit
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && r_in.button_pressed && r_state.phase != PH_PREHEAT
            && r_state.phase != PH_REFLOW)
        |=> (r_state.phase == PH_PREHEAT && r_state.tick_count == 16'd0
            && r_state.led_level))
        else $error("start poll did not enter preheat cleanly");

    // a processed poll always produces a result beat
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go |=> r_out_valid)
        else $error("processed poll left no result");

endmodule

`default_nettype wire

@@ tb/tb_reflow_oven_profile_checker.sv @@
// checker for the reflow oven profile controller: predicts each result beat and compares it
`timescale 1ns / 100ps

module tb_reflow_oven_profile_checker
    import rfo_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_in_valid,
    input  wire         i_in_stall,
    input  wire         i_button_pressed,
    input  wire         i_sense_level,
    input  wire  [15:0] i_adc_sample,
    input  wire         i_out_valid,
    input  wire         i_out_stall,
    input  wire         i_fire_triac,
    input  wire         i_led_on,
    input  wire  [1:0]  i_phase,
    input  wire         i_heater_on,
    input  wire  [15:0] i_filtered_level,
    output int          o_fail_count,
    output int          o_pending
);

    // predicted profile registers
    logic [15:0] thr_preheat;
    logic [15:0] thr_reflow;
    logic [15:0] dur_preheat;
    logic [15:0] dur_reflow;

    // predicted controller state
    logic [1:0]  cur_phase;
    logic [15:0] half_cycles;
    logic        sense_was_high;
    logic [15:0] filt_level;
    logic        heat_req;
    logic        led_level;

    t_result     oven_results[$];
    t_poll       poll;
    t_result     predicted;
    t_result     want;
    t_result     got;
    int          fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic step_controller(input t_poll p, output t_result r);
        logic fire_now;
        fire_now = 1'b0;
        // the unused phase code behaves as idle
        if (cur_phase != PH_PREHEAT && cur_phase != PH_REFLOW) begin
            cur_phase = PH_IDLE;
            if (p.button_pressed) begin
                cur_phase   = PH_PREHEAT;
                led_level   = 1'b1;
                half_cycles = 16'd0;
            end else begin
                half_cycles = half_cycles + 16'd1;
                led_level   = half_cycles[BLINK_BIT];
            end
        end else begin
            if (p.sense_level) begin
                sense_was_high = 1'b1;
            end else begin
                if (sense_was_high) begin
                    fire_now    = heat_req;
                    half_cycles = half_cycles + 16'd1;
                    if (cur_phase == PH_PREHEAT)
                        led_level = ~led_level;
                end
                sense_was_high = 1'b0;
            end
            filt_level = (p.adc_sample >> 2) + (filt_level - (filt_level >> 2));
            if (cur_phase == PH_PREHEAT) begin
                heat_req = (filt_level >= thr_preheat);
                if (half_cycles > dur_preheat) begin
                    cur_phase   = PH_REFLOW;
                    led_level   = 1'b1;
                    half_cycles = 16'd0;
                end
            end else begin
                heat_req = (filt_level >= thr_reflow);
                if (half_cycles > dur_reflow) begin
                    cur_phase   = PH_IDLE;
                    half_cycles = 16'd0;
                end
            end
        end
        r.fire_triac     = fire_now;
        r.led_on         = led_level;
        r.phase          = cur_phase;
        r.heater_on      = heat_req;
        r.filtered_level = filt_level;
    endtask

    task automatic check_field(input string field, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
                     exp_val, act_val);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_preheat    = RST_PREHEAT_THRESHOLD;
            thr_reflow     = RST_REFLOW_THRESHOLD;
            dur_preheat    = RST_PREHEAT_HALF_CYCLES;
            dur_reflow     = RST_REFLOW_HALF_CYCLES;
            cur_phase      = PH_IDLE;
            half_cycles    = 16'd0;
            sense_was_high = 1'b0;
            filt_level     = 16'd0;
            heat_req       = 1'b0;
            led_level      = 1'b0;
            oven_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PREHEAT_THRESHOLD:   thr_preheat = i_cfg_data;
                    REG_REFLOW_THRESHOLD:    thr_reflow  = i_cfg_data;
                    REG_PREHEAT_HALF_CYCLES: dur_preheat = i_cfg_data;
                    REG_REFLOW_HALF_CYCLES:  dur_reflow  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                poll = {i_button_pressed, i_sense_level, i_adc_sample};
                step_controller(poll, predicted);
                oven_results.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_fire_triac, i_led_on, i_phase, i_heater_on, i_filtered_level};
                if (oven_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %0h",
                             $time, got);
                    fail_total++;
                end else begin
                    want = oven_results.pop_front();
                    check_field("fire_triac", want.fire_triac, got.fire_triac);
                    check_field("led_on", want.led_on, got.led_on);
                    check_field("phase", want.phase, got.phase);
                    check_field("heater_on", want.heater_on, got.heater_on);
                    check_field("filtered_level", want.filtered_level, got.filtered_level);
                end
            end
        end
        o_pending    <= oven_results.size();
        o_fail_count <= fail_total;
    end

endmodule

@@ tb/tb_reflow_oven_profile_controller_top.sv @@
// testbench top for the reflow oven profile controller: stimulus, stalls, watchdog and verdict
`timescale 1ns / 100ps

module tb_reflow_oven_profile_controller_top;
    import rfo_pkg::*;

    // cycles with no beat and no register write before the run is declared hung
    localparam int QUIET_LIMIT = 1000;

    logic        clk;
    logic        rst_n;

    // register write port
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // poll channel
    logic        poll_valid;
    logic        poll_stall;
    logic        button;
    logic        sense;
    logic [15:0] adc;

    // result channel
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic        fire;
    logic        led;
    logic [1:0]  phase;
    logic        heater;
    logic [15:0] filtered;

    int          fail_count;
    int          pending;

    // stimulus bookkeeping
    bit          idle_on = 1'b1;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          oven_temp;
    int          seg_items;
    logic        sense_lvl;
    logic        press;
    logic [15:0] sample;

    reflow_oven_profile_controller_top uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (poll_valid),
        .o_in_stall       (poll_stall),
        .i_button_pressed (button),
        .i_sense_level    (sense),
        .i_adc_sample     (adc),
        .o_out_valid      (res_valid),
        .i_out_stall      (res_stall),
        .o_fire_triac     (fire),
        .o_led_on         (led),
        .o_phase          (phase),
        .o_heater_on      (heater),
        .o_filtered_level (filtered)
    );

    tb_reflow_oven_profile_checker profile_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (poll_valid),
        .i_in_stall       (poll_stall),
        .i_button_pressed (button),
        .i_sense_level    (sense),
        .i_adc_sample     (adc),
        .i_out_valid      (res_valid),
        .i_out_stall      (res_stall),
        .i_fire_triac     (fire),
        .i_led_on         (led),
        .i_phase          (phase),
        .i_heater_on      (heater),
        .i_filtered_level (filtered),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 20 ns clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // clamp a signed value into the 16-bit reading range
    function automatic logic [15:0] clamp16(input int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    // a threshold somewhere around the current oven temperature, so the heater toggles
    function automatic logic [15:0] near_temp();
        return clamp16(oven_temp + int'($urandom_range(0, 16000)) - 8000);
    endfunction

    // one poll beat; may open with a random gap, returns right after the accepting edge
    task automatic send_poll(input logic b, input logic s, input logic [15:0] a);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            poll_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        poll_valid <= 1'b1;
        button     <= b;
        sense      <= s;
        adc        <= a;
        @(posedge clk);
        while (poll_stall) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // new profile: drain every outstanding result first, then write all four registers
    task automatic program_profile(input logic [15:0] thr_pre, input logic [15:0] thr_ref,
                                   input logic [15:0] dur_pre, input logic [15:0] dur_ref);
        poll_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        write_register(REG_PREHEAT_THRESHOLD, thr_pre);
        write_register(REG_REFLOW_THRESHOLD, thr_ref);
        write_register(REG_PREHEAT_HALF_CYCLES, dur_pre);
        write_register(REG_REFLOW_HALF_CYCLES, dur_ref);
        cfg_we <= 1'b0;
    endtask

    // result side back-pressure: random stall bursts while idling is on
    always @(posedge clk) begin
        if (!idle_on) begin
            stall_left = 0;
            res_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            res_stall <= 1'b1;
        end else begin
            res_stall <= 1'b0;
        end
    end

    // watchdog: any beat or register write counts as progress
    always @(posedge clk) begin
        if (!rst_n || (poll_valid && !poll_stall) || (res_valid && !res_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_reflow_oven_profile_controller_top failed");
            $finish;
        end
    end

    initial begin
        // everything known from time zero, reset held low at the start
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_PREHEAT_THRESHOLD;
        cfg_data   <= 16'd0;
        poll_valid <= 1'b0;
        button     <= 1'b0;
        sense      <= 1'b0;
        adc        <= 16'd0;
        oven_temp  = $urandom_range(0, 65535);
        sense_lvl  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset profile: idle polls ignore sense and sample
        send_poll(1'b0, 1'b1, 16'hFFFF);
        send_poll(1'b0, 1'b0, 16'h0000);
        // start press, then a press while running is ignored
        send_poll(1'b1, 1'b1, 16'hFFFF);
        send_poll(1'b1, 1'b1, 16'hFFFF);
        // falling edges while the full-scale reading pushes the filter over the threshold
        send_poll(1'b0, 1'b0, 16'hFFFF);
        send_poll(1'b0, 1'b0, 16'hFFFF);
        send_poll(1'b0, 1'b1, 16'hFFFF);
        send_poll(1'b0, 1'b0, 16'hFFFF);
        send_poll(1'b0, 1'b1, 16'hFFFF);
        send_poll(1'b0, 1'b0, 16'hFFFF);

        // extreme profile: heater always on in preheat, never in reflow, zero durations
        program_profile(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        // count already past zero, so preheat hands over to reflow at once
        send_poll(1'b0, 1'b1, 16'h8000);
        // edge in reflow fires the triac and finishes the profile
        send_poll(1'b0, 1'b0, 16'h0000);
        send_poll(1'b0, 1'b0, 16'hFFFF);
        send_poll(1'b1, 1'b0, 16'h0000);
        // preheat edge toggles the led, then leaves for reflow
        send_poll(1'b0, 1'b1, 16'h0000);
        send_poll(1'b0, 1'b0, 16'h0000);
        send_poll(1'b0, 1'b1, 16'hFFFF);
        send_poll(1'b0, 1'b0, 16'hFFFF);

        // random part: one segment per profile, the last one without any idling
        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 1)
                program_profile(16'hFFFF, 16'h0000, 16'hFFFE, 16'hFFFE);
            else
                program_profile(near_temp(), near_temp(), 16'($urandom_range(0, 40)),
                                16'($urandom_range(0, 40)));
            seg_items = (seg == 1) ? 100 : 240;
            for (int n = 0; n < seg_items; n++) begin
                if (seg == 5)
                    idle_on = 1'b0;
                else if (n % 60 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                // slowly drifting temperature with some full-range noise
                oven_temp = int'(clamp16(oven_temp + int'($urandom_range(0, 4000)) - 2000));
                if ($urandom_range(0, 3) == 0)
                    sample = 16'($urandom_range(0, 65535));
                else
                    sample = clamp16(oven_temp + int'($urandom_range(0, 1000)) - 500);
                // mostly alternating sense gives frequent half-cycle edges
                if ($urandom_range(0, 2) != 0)
                    sense_lvl = ~sense_lvl;
                press = ($urandom_range(0, 15) == 0);
                send_poll(press, sense_lvl, sample);
            end
        end

        // drain and let the pipeline settle
        poll_valid <= 1'b0;
        idle_on = 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("tb_reflow_oven_profile_controller_top passed");
        else
            $display("tb_reflow_oven_profile_controller_top failed");
        $finish;
    end

endmodule
